### hw/rtl/modbus_rtu_slave_responder_macros.svh
// Assertion helpers for the checker in mrs_checker.sv.
`ifndef MODBUS_RTU_SLAVE_RESPONDER_MACROS_SVH
`define MODBUS_RTU_SLAVE_RESPONDER_MACROS_SVH

// Condition must hold in the same cycle, outside reset.
`define MRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrs assertion failed");

// Condition must hold in the next cycle, outside reset.
`define MRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrs assertion failed");

// Next-cycle check that also runs while reset is applied.
`define MRS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mrs reset assertion failed");

`endif

### hw/rtl/mrs_pkg.sv
package mrs_pkg;

  // Default sizes
  localparam int RX_BYTES_DEF  = 256;
  localparam int MAP_WORDS_DEF = 16;
  localparam int STORE_DEPTH   = 256;
  localparam int STORE_AW      = 8;

  // Reset values and CRC constants
  localparam logic [7:0]  SLAVE_ADDRESS_RST = 8'd1;
  localparam logic [4:0]  MAP_WORDS_RST     = 5'd16;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  EXC_FLAG          = 8'h80;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WORDS     = 1'd1;

  // Function and exception codes
  localparam logic [7:0] FUNC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FUNC_WRITE_SINGLE  = 8'd6;
  localparam logic [7:0] FUNC_WRITE_MULTI   = 8'd16;
  localparam logic [7:0] EXC_ILLEGAL_FUNC   = 8'd1;
  localparam logic [7:0] EXC_ILLEGAL_ADDR   = 8'd2;
  localparam logic [7:0] EXC_ILLEGAL_VALUE  = 8'd3;

  // Response kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_READ        = 2'd0;
  localparam kind_t KIND_ECHO        = 2'd1;
  localparam kind_t KIND_WRITE_MULTI = 2'd2;
  localparam kind_t KIND_EXC         = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;
    logic rx_take;
    logic load_step;
    logic decide;
    logic wr_hi;
    logic wr_lo;
    logic wr_put;
    logic emit_step;
  } mrs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic rx_end;
    logic load_done;
    logic frame_ok;
    logic multi_write;
    logic wr_done;
    logic emit_fire;
    logic emit_last;
  } mrs_status_t;

  // CRC-16, reflected, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

### hw/rtl/mrs_ctrl.sv
module mrs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  mrs_pkg::mrs_status_t  status,
  output logic                  in_stall,
  output mrs_pkg::mrs_cmd_t     cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WR_HI  = 3'd4;
  localparam logic [2:0] S_WR_LO  = 3'd5;
  localparam logic [2:0] S_WR_PUT = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.rx_take = in_valid;
        if (in_valid && status.rx_end) state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_step = 1'b1;
        if (status.load_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (!status.frame_ok) state_next = S_IDLE;
        else if (status.multi_write) state_next = S_WR_HI;
        else state_next = S_EMIT;
      end
      S_WR_HI: begin
        cmd.wr_hi  = 1'b1;
        state_next = S_WR_LO;
      end
      S_WR_LO: begin
        cmd.wr_lo  = 1'b1;
        state_next = S_WR_PUT;
      end
      S_WR_PUT: begin
        cmd.wr_put = 1'b1;
        state_next = status.wr_done ? S_EMIT : S_WR_HI;
      end
      S_EMIT: begin
        cmd.emit_step = 1'b1;
        if (status.emit_fire && status.emit_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hw/rtl/mrs_datapath.sv
module mrs_datapath #(
  parameter int RX_BYTES  = mrs_pkg::RX_BYTES_DEF,
  parameter int MAP_WORDS = mrs_pkg::MAP_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mrs_pkg::mrs_cmd_t             cmd,
  output mrs_pkg::mrs_status_t          status,
  input  logic [7:0]                    rx_byte,
  input  logic                          frame_end,
  input  logic                          line_error,
  input  logic                          cfg_valid,
  input  logic [mrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [7:0]                    tx_byte,
  output logic                          last_byte
);

  localparam int LEN_W = $clog2(RX_BYTES + 1);
  localparam int HW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W = $clog2(MAP_WORDS + 1);
  localparam int TX_W  = $clog2(2 * MAP_WORDS + 12);

  // Configuration registers
  logic [7:0] slave_address;
  logic [4:0] map_words_in_use;
  logic [4:0] limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address    <= mrs_pkg::SLAVE_ADDRESS_RST;
      map_words_in_use <= mrs_pkg::MAP_WORDS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mrs_pkg::CFG_SLAVE_ADDRESS: slave_address    <= cfg_data;
        mrs_pkg::CFG_MAP_WORDS:     map_words_in_use <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign limit = (map_words_in_use < 5'(MAP_WORDS)) ? map_words_in_use : 5'(MAP_WORDS);

  // Receive store, one write and one registered read port
  logic [7:0] frame_store [mrs_pkg::STORE_DEPTH];
  logic [mrs_pkg::STORE_AW-1:0] st_waddr, st_raddr, clr_addr;
  logic [7:0] st_wdata, st_rdata;
  logic       st_we;

  always_ff @(posedge clk) begin
    if (st_we) frame_store[st_waddr] <= st_wdata;
    st_rdata <= frame_store[st_raddr];
  end

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign status.clear_done = (clr_addr == '1);

  // Frame reception with running CRC
  logic [LEN_W-1:0] frame_length;
  logic [15:0]      running_crc, crc_new;
  logic             n_ok, crc_ok;

  assign crc_new       = mrs_pkg::crc_byte(running_crc, rx_byte);
  assign status.rx_end = !line_error &&
                         (frame_end || frame_length == LEN_W'(RX_BYTES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= '0;
      running_crc  <= mrs_pkg::CRC_INIT;
      n_ok         <= 1'b0;
      crc_ok       <= 1'b0;
    end else if (cmd.rx_take) begin
      if (line_error) begin
        frame_length <= '0;
        running_crc  <= mrs_pkg::CRC_INIT;
      end else if (status.rx_end) begin
        frame_length <= '0;
        running_crc  <= mrs_pkg::CRC_INIT;
        n_ok         <= (frame_length >= LEN_W'(3));
        crc_ok       <= (crc_new == 16'h0000);
      end else begin
        frame_length <= frame_length + 1'b1;
        running_crc  <= crc_new;
      end
    end
  end

  assign st_we    = cmd.clear_step || (cmd.rx_take && !line_error);
  assign st_waddr = cmd.clear_step ? clr_addr : mrs_pkg::STORE_AW'(frame_length);
  assign st_wdata = cmd.clear_step ? 8'h00 : rx_byte;

  // Header load: store bytes 0 to 7 into registers
  logic [3:0] ld_cnt;
  logic [7:0] hdr [8];

  assign status.load_done = (ld_cnt == 4'd8);

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_cnt <= '0;
    end else if (cmd.load_step) begin
      ld_cnt <= status.load_done ? 4'd0 : ld_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_step && ld_cnt != 4'd0) hdr[3'(ld_cnt - 4'd1)] <= st_rdata;
  end

  // Request fields
  logic [7:0]  func;
  logic [15:0] start, count;

  assign func  = hdr[1];
  assign start = {hdr[2], hdr[3]};
  assign count = {hdr[4], hdr[5]};

  // Frame checks and request decode
  logic                range_bad, single_bad, bc_bad;
  mrs_pkg::kind_t      dec_kind;
  logic [7:0]          dec_code;

  assign status.frame_ok = n_ok && crc_ok && (hdr[0] == slave_address);
  assign range_bad  = (17'(start) + 17'(count)) > 17'(limit);
  assign single_bad = start >= 16'(limit);
  assign bc_bad     = 17'(hdr[6]) != {count, 1'b0};

  always_comb begin
    dec_kind = mrs_pkg::KIND_EXC;
    dec_code = mrs_pkg::EXC_ILLEGAL_FUNC;
    unique case (func)
      mrs_pkg::FUNC_READ_HOLDING: begin
        if (range_bad) dec_code = mrs_pkg::EXC_ILLEGAL_ADDR;
        else dec_kind = mrs_pkg::KIND_READ;
      end
      mrs_pkg::FUNC_WRITE_SINGLE: begin
        if (single_bad) dec_code = mrs_pkg::EXC_ILLEGAL_ADDR;
        else dec_kind = mrs_pkg::KIND_ECHO;
      end
      mrs_pkg::FUNC_WRITE_MULTI: begin
        if (range_bad) dec_code = mrs_pkg::EXC_ILLEGAL_ADDR;
        else if (bc_bad) dec_code = mrs_pkg::EXC_ILLEGAL_VALUE;
        else dec_kind = mrs_pkg::KIND_WRITE_MULTI;
      end
      default: ;
    endcase
  end

  assign status.multi_write = (dec_kind == mrs_pkg::KIND_WRITE_MULTI) && (count != 16'h0000);

  // Response registers
  mrs_pkg::kind_t  kind;
  logic [7:0]      exc_code;
  logic [TX_W-1:0] body_len, tx_idx;
  logic [15:0]     tx_crc;
  logic [CNT_W-1:0] wi;
  logic [7:0]      wr_hi_byte;

  // Multi-register write: store byte addresses for word wi
  logic [7:0] wi_ext, addr_hi, addr_lo;

  assign wi_ext  = 8'(wi);
  assign addr_hi = 8'd7 + {wi_ext[6:0], 1'b0};
  assign addr_lo = addr_hi + 8'd1;

  always_comb begin
    st_raddr = '0;
    if (cmd.load_step) st_raddr = mrs_pkg::STORE_AW'(ld_cnt[2:0]);
    else if (cmd.wr_hi) st_raddr = addr_hi;
    else if (cmd.wr_lo) st_raddr = addr_lo;
  end

  assign status.wr_done = (16'(wi) + 16'd1) == count;

  // Holding registers
  logic [15:0]   hold_regs [MAP_WORDS];
  logic          hr_we;
  logic [HW-1:0] hr_waddr, hr_raddr;
  logic [15:0]   hr_wdata, hrv;

  assign hr_we    = (cmd.decide && status.frame_ok && dec_kind == mrs_pkg::KIND_ECHO) ||
                    cmd.wr_put;
  assign hr_waddr = cmd.wr_put ? HW'(start) + HW'(wi) : HW'(start);
  assign hr_wdata = cmd.wr_put ? {wr_hi_byte, st_rdata} : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_WORDS; i++) hold_regs[i] <= 16'h0000;
    end else if (hr_we) begin
      hold_regs[hr_waddr] <= hr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_lo) wr_hi_byte <= st_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wi <= '0;
    end else if (cmd.decide) begin
      wi <= '0;
    end else if (cmd.wr_put) begin
      wi <= wi + 1'b1;
    end
  end

  // Emit sequencing
  logic [TX_W-1:0] doff;
  logic [7:0]      body_byte, emit_byte;
  logic            crc_lo_pos, crc_hi_pos;

  assign doff     = tx_idx - TX_W'(3);
  assign hr_raddr = HW'(start) + HW'(doff >> 1);
  assign hrv      = hold_regs[hr_raddr];

  assign crc_lo_pos = (kind != mrs_pkg::KIND_ECHO) && (tx_idx == body_len);
  assign crc_hi_pos = (kind != mrs_pkg::KIND_ECHO) && (tx_idx == body_len + TX_W'(1));

  always_comb begin
    body_byte = hdr[tx_idx[2:0]];
    case (kind)
      mrs_pkg::KIND_READ: begin
        if (tx_idx == TX_W'(0)) body_byte = slave_address;
        else if (tx_idx == TX_W'(1)) body_byte = hdr[1];
        else if (tx_idx == TX_W'(2)) body_byte = {count[6:0], 1'b0};
        else body_byte = doff[0] ? hrv[7:0] : hrv[15:8];
      end
      mrs_pkg::KIND_EXC: begin
        if (tx_idx == TX_W'(0)) body_byte = slave_address;
        else if (tx_idx == TX_W'(1)) body_byte = hdr[1] | mrs_pkg::EXC_FLAG;
        else body_byte = exc_code;
      end
      mrs_pkg::KIND_WRITE_MULTI: begin
        if (tx_idx == TX_W'(0)) body_byte = slave_address;
      end
      default: ;
    endcase
  end

  assign emit_byte = crc_lo_pos ? tx_crc[7:0] : (crc_hi_pos ? tx_crc[15:8] : body_byte);

  assign status.emit_last = (kind == mrs_pkg::KIND_ECHO) ? (tx_idx == TX_W'(7)) : crc_hi_pos;
  assign status.emit_fire = cmd.emit_step && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      kind     <= dec_kind;
      exc_code <= dec_code;
      tx_idx   <= '0;
      tx_crc   <= mrs_pkg::CRC_INIT;
      case (dec_kind)
        mrs_pkg::KIND_READ:        body_len <= TX_W'(3) + TX_W'({count[CNT_W-1:0], 1'b0});
        mrs_pkg::KIND_ECHO:        body_len <= TX_W'(8);
        mrs_pkg::KIND_WRITE_MULTI: body_len <= TX_W'(6);
        default:                   body_len <= TX_W'(3);
      endcase
    end else if (status.emit_fire) begin
      tx_idx <= tx_idx + 1'b1;
      if (tx_idx < body_len) tx_crc <= mrs_pkg::crc_byte(tx_crc, body_byte);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.emit_fire) begin
      tx_byte   <= emit_byte;
      last_byte <= status.emit_last;
    end
  end

endmodule

### hw/rtl/modbus_rtu_slave_responder.sv
// Bytes are taken one per cycle while a frame is received.
// A frame end is followed by header load and decode, plus the WR_HI, WR_LO and
// WR_PUT steps per register of a multi-register write; then one response byte
// per cycle unless stalled. The header load uses the one store read port.
// After reset a sweep clears all 256 receive store entries with in_stall high;
// configuration writes are taken at all times.
module modbus_rtu_slave_responder #(
  parameter int RX_BYTES  = mrs_pkg::RX_BYTES_DEF,
  parameter int MAP_WORDS = mrs_pkg::MAP_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    rx_byte,
  input  logic                          frame_end,
  input  logic                          line_error,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    tx_byte,
  output logic                          last_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  mrs_pkg::mrs_cmd_t    cmd;
  mrs_pkg::mrs_status_t status;

  // Registers accept a write every cycle
  assign cfg_ready = 1'b1;

  mrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  mrs_datapath #(
    .RX_BYTES  (RX_BYTES),
    .MAP_WORDS (MAP_WORDS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .rx_byte    (rx_byte),
    .frame_end  (frame_end),
    .line_error (line_error),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .tx_byte    (tx_byte),
    .last_byte  (last_byte)
  );

endmodule

### hw/rtl/mrs_checker.sv
`include "modbus_rtu_slave_responder_macros.svh"

module mrs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       line_error,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] tx_byte,
  input logic       last_byte
);

  // A stalled response byte holds
  `MRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tx_byte) && $stable(last_byte))

  // No new input while a response frame is still going out
  `MRS_ASSERT_NOW(a_frame_blocks_input, out_valid && !last_byte, in_stall)

  // A line error never starts frame processing
  `MRS_ASSERT_NEXT(a_line_error_idle, in_valid && !in_stall && line_error, !in_stall)

  // Store clearing holds off input right after reset
  `MRS_ASSERT_RST(a_clear_after_reset, rst, in_stall)

endmodule

bind modbus_rtu_slave_responder mrs_checker u_mrs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .line_error (line_error),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .tx_byte    (tx_byte),
  .last_byte  (last_byte)
);

### tb/modbus_checker.sv
module modbus_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       frame_end,
  input  logic       line_error,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] tx_byte,
  input  logic       last_byte,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         reply_count
);
  import mrs_pkg::*;

  localparam int RXB = 256;
  localparam int MAPW = 16;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_byte_t;

  // model state
  logic [7:0]  rx_store [256];
  logic [15:0] regs [MAPW];
  int          rx_len;
  logic [15:0] rx_crc;
  logic [7:0]  own_addr;
  logic [4:0]  map_used;
  reply_byte_t reply_q [$];

  assign pending = reply_q.size();

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  // append a frame with its CRC to the expected replies
  task automatic queue_reply(input logic [7:0] buf_b [$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (buf_b[i]) c = crc_step(c, buf_b[i]);
    buf_b.push_back(c[7:0]);
    buf_b.push_back(c[15:8]);
    foreach (buf_b[i]) reply_q.push_back('{buf_b[i], i == buf_b.size() - 1});
  endtask

  task automatic queue_exception(input logic [7:0] fn, input logic [7:0] code);
    logic [7:0] b [$];
    b = {own_addr, fn | EXC_FLAG, code};
    queue_reply(b);
  endtask

  // predict the response to one received byte
  task automatic take_byte(input logic [7:0] b, input logic fe, input logic le);
    int n, lim, start, cnt;
    logic [15:0] c;
    logic [7:0] fn;
    logic [7:0] o [$];
    if (le) begin
      rx_len = 0;
      rx_crc = CRC_INIT;
      return;
    end
    if (rx_len < RXB) begin
      rx_store[rx_len] = b;
      rx_len++;
      rx_crc = crc_step(rx_crc, b);
    end
    if (!fe && rx_len < RXB) return;
    n = rx_len;
    c = rx_crc;
    rx_len = 0;
    rx_crc = CRC_INIT;
    if (n < 4 || c != 0 || rx_store[0] != own_addr) return;
    lim = (map_used < MAPW) ? map_used : MAPW;
    fn = rx_store[1];
    start = {rx_store[2], rx_store[3]};
    cnt = {rx_store[4], rx_store[5]};
    if (fn == FUNC_READ_HOLDING) begin
      if (start + cnt > lim) begin
        queue_exception(fn, EXC_ILLEGAL_ADDR);
        return;
      end
      o = {own_addr, fn, 8'((cnt * 2) & 255)};
      for (int i = 0; i < cnt; i++) begin
        o.push_back(regs[start + i][15:8]);
        o.push_back(regs[start + i][7:0]);
      end
      queue_reply(o);
    end else if (fn == FUNC_WRITE_SINGLE) begin
      if (start >= lim) begin
        queue_exception(fn, EXC_ILLEGAL_ADDR);
        return;
      end
      regs[start] = 16'(cnt);
      for (int i = 0; i < 8; i++) reply_q.push_back('{rx_store[i], i == 7});
    end else if (fn == FUNC_WRITE_MULTI) begin
      if (start + cnt > lim) begin
        queue_exception(fn, EXC_ILLEGAL_ADDR);
        return;
      end
      if (int'(rx_store[6]) != cnt * 2) begin
        queue_exception(fn, EXC_ILLEGAL_VALUE);
        return;
      end
      for (int i = 0; i < cnt; i++)
        regs[start + i] = {rx_store[7 + i * 2], rx_store[8 + i * 2]};
      o = {own_addr, fn, rx_store[2], rx_store[3], rx_store[4], rx_store[5]};
      queue_reply(o);
    end else begin
      queue_exception(fn, EXC_ILLEGAL_FUNC);
    end
  endtask

  // watch every transfer at the rising edge
  always @(posedge clk) begin
    reply_byte_t e;
    if (rst) begin
      foreach (rx_store[i]) rx_store[i] = '0;
      foreach (regs[i]) regs[i] = '0;
      rx_len = 0;
      rx_crc = CRC_INIT;
      own_addr = SLAVE_ADDRESS_RST;
      map_used = MAP_WORDS_RST;
      reply_q.delete();
      fail_count = 0;
      reply_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SLAVE_ADDRESS) own_addr = cfg_data;
        else map_used = cfg_data[4:0];
      end
      if (out_valid && !out_stall) begin
        reply_count++;
        if (reply_q.size() == 0) begin
          $error("unexpected response byte %h", tx_byte);
          fail_count++;
        end else begin
          e = reply_q.pop_front();
          if (tx_byte !== e.data) begin
            $error("tx_byte expected %h actual %h", e.data, tx_byte);
            fail_count++;
          end
          if (last_byte !== e.last) begin
            $error("last_byte expected %b actual %b", e.last, last_byte);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) take_byte(rx_byte, frame_end, line_error);
    end
  end
endmodule

### tb/tb_top.sv
module tb_top;
  import mrs_pkg::*;

  logic       clk = 0;
  logic       rst = 1;
  logic       in_valid = 0;
  logic       in_stall;
  logic [7:0] rx_byte = 0;
  logic       frame_end = 0;
  logic       line_error = 0;
  logic       out_valid;
  logic       out_stall = 0;
  logic [7:0] tx_byte;
  logic       last_byte;
  logic       cfg_valid = 0;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SLAVE_ADDRESS;
  logic [7:0] cfg_data = 0;
  int         fail_count, pending, reply_count;
  int         cycle = 0;
  int         items_sent = 0;
  int         frames_sent = 0;
  bit         hold_off = 0;
  bit         stall_bursty = 1;

  logic [7:0] my_addr = SLAVE_ADDRESS_RST;

  always #1 clk = ~clk;

  modbus_rtu_slave_responder dut (.*);

  modbus_checker chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else if (stall_bursty) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= 0;
  end

  // one byte transfer; valid stays high when another follows at once
  task automatic send_byte(input logic [7:0] b, input logic fe, input logic le);
    in_valid <= 1;
    rx_byte <= b;
    frame_end <= fe;
    line_error <= le;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // frame with correct CRC appended
  task automatic send_frame(input logic [7:0] body [$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) c = crc_byte(c, body[i]);
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    foreach (body[i]) send_byte(body[i], i == body.size() - 1, 1'b0);
    frames_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    if (idx == CFG_SLAVE_ADDRESS) my_addr = val;
  endtask

  // random request with random content; some are malformed or lack a valid CRC
  task automatic random_request();
    logic [7:0] b [$];
    logic [7:0] fn;
    int start, cnt, k;
    k = $urandom_range(0, 9);
    fn = (k < 3) ? FUNC_READ_HOLDING : (k < 6) ? FUNC_WRITE_SINGLE :
         (k < 9) ? FUNC_WRITE_MULTI : 8'($urandom);
    start = $urandom_range(0, 17);
    cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5);
    if (($urandom_range(0, 7)) == 0) start = $urandom_range(0, 65535);
    b = {($urandom_range(0, 9) == 0) ? 8'($urandom) : my_addr, fn,
         8'(start >> 8), 8'(start), 8'(cnt >> 8), 8'(cnt)};
    if (fn == FUNC_WRITE_MULTI) begin
      b.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'(cnt * 2));
      for (int i = 0; i < (cnt & 7) * 2; i++) b.push_back(8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) begin
      b[$urandom_range(0, b.size() - 1)] ^= 8'($urandom_range(1, 255));
      foreach (b[i]) send_byte(b[i], i == b.size() - 1, 1'b0);
    end else begin
      send_frame(b);
    end
  endtask

  logic [7:0] f [$];

  initial begin
    repeat (3) @(negedge clk);
    rst <= 0;

    // directed: each function, exceptions, count zero, stale reads
    f = {8'h01, FUNC_WRITE_MULTI, 8'h00, 8'h00, 8'h00, 8'h02, 8'h04,
         8'hFF, 8'hFF, 8'h00, 8'h00};
    send_frame(f);
    f = {8'h01, FUNC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h10};
    send_frame(f);
    f = {8'h01, FUNC_WRITE_SINGLE, 8'h00, 8'h0F, 8'hA5, 8'h5A};
    send_frame(f);
    f = {8'h01, FUNC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(f);
    f = {8'h01, FUNC_READ_HOLDING, 8'h00, 8'h0F, 8'h00, 8'h02};
    send_frame(f);
    f = {8'h01, FUNC_WRITE_SINGLE, 8'h00, 8'h10, 8'h00, 8'h01};
    send_frame(f);
    f = {8'h01, FUNC_WRITE_MULTI, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(f);
    f = {8'h01, FUNC_WRITE_MULTI, 8'h00, 8'h00, 8'h00, 8'h01, 8'h05, 8'h12, 8'h34};
    send_frame(f);
    f = {8'h01, 8'hFF};
    send_frame(f);
    f = {8'h01, 8'h00};
    send_frame(f);
    // short frames, line errors (with and without frame end)
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    drain();

    // full store with no frame end
    write_cfg(CFG_SLAVE_ADDRESS, 8'h00);
    for (int i = 0; i < 256; i++) send_byte(8'($urandom), 1'b0, 1'b0);
    drain();

    // random phases over several settings; one long receiver hold-off
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_cfg(CFG_SLAVE_ADDRESS, 8'hFF); write_cfg(CFG_MAP_WORDS, 8'd0); end
        1: begin write_cfg(CFG_SLAVE_ADDRESS, 8'h00); write_cfg(CFG_MAP_WORDS, 8'd31); end
        2: begin write_cfg(CFG_SLAVE_ADDRESS, 8'h11); write_cfg(CFG_MAP_WORDS, 8'd16); end
        3: begin
          write_cfg(CFG_SLAVE_ADDRESS, 8'($urandom));
          write_cfg(CFG_MAP_WORDS, 8'($urandom_range(1, 15)));
        end
        default: begin write_cfg(CFG_SLAVE_ADDRESS, 8'h01); write_cfg(CFG_MAP_WORDS, 8'd16); end
      endcase
      stall_bursty = (ph != 2);
      if (ph == 4) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int r = 0; r < 6; r++) begin
        random_request();
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'($urandom), 1'b1);
        if ($urandom_range(0, 14) == 0) send_byte(8'($urandom), 1'b1, 1'b0);
      end
      drain();
    end

    $display("Sent %0d bytes in %0d CRC-valid frames, checked %0d response bytes.",
             items_sent, frames_sent, reply_count);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
